[hw/rtl/two_button_event_detector_top_assert.svh]
// Assertion macros used by the event detector checker
`ifndef TWO_BUTTON_EVENT_DETECTOR_TOP_ASSERT_SVH
`define TWO_BUTTON_EVENT_DETECTOR_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is high
`define TBED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked through reset as well
`define TBED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/tbed_pkg.sv]
// Types and constants of the two-button event detector
package tbed_pkg;

   // Machine phases
   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_POLL = 2'd1,
      PH_LOCK = 2'd2,
      PH_IACT = 2'd3
   } phase_type;

   // Event codes on the result channel
   typedef enum logic [1:0] {
      EV_DOWN = 2'd0,
      EV_HOLD = 2'd1,
      EV_UP   = 2'd2,
      EV_HLUP = 2'd3
   } event_kind_type;

   // Field widths
   localparam int STAMP_W     = 32;
   localparam int WINDOW_W    = 16;
   localparam int PORT_KEYS_W = 2;
   localparam int CSR_INDEX_W = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_WINDOW   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_JITTER_WINDOW = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TIME     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INACTIVE_TIME = 8'd3;

   // Register reset values in ms
   localparam logic [WINDOW_W-1:0] POLL_WINDOW_RESET   = 16'd150;
   localparam logic [WINDOW_W-1:0] JITTER_WINDOW_RESET = 16'd80;
   localparam logic [WINDOW_W-1:0] HOLD_TIME_RESET     = 16'd900;
   localparam logic [WINDOW_W-1:0] INACTIVE_TIME_RESET = 16'd100;

   typedef struct packed {
      logic [WINDOW_W-1:0] poll_window_ms;
      logic [WINDOW_W-1:0] jitter_window_ms;
      logic [WINDOW_W-1:0] hold_time_ms;
      logic [WINDOW_W-1:0] inactive_time_ms;
   } cfg_type;

   // One event from the core to the result register
   typedef struct packed {
      logic                   valid;
      event_kind_type         kind;
      logic [PORT_KEYS_W-1:0] keys;
   } event_type;

   // What one lock-phase step does
   typedef struct packed {
      logic           refresh_jitter;
      logic           set_hold;
      logic           emit;
      event_kind_type kind;
      logic           release_keys;
   } lock_action_type;

   localparam lock_action_type ACT_NONE         = '{1'b0, 1'b0, 1'b0, EV_DOWN, 1'b0};
   localparam lock_action_type ACT_REFRESH      = '{1'b1, 1'b0, 1'b0, EV_DOWN, 1'b0};
   localparam lock_action_type ACT_HOLD         = '{1'b0, 1'b1, 1'b1, EV_HOLD, 1'b0};
   localparam lock_action_type ACT_HOLD_REFRESH = '{1'b1, 1'b1, 1'b1, EV_HOLD, 1'b0};
   localparam lock_action_type ACT_UP           = '{1'b0, 1'b0, 1'b1, EV_UP,   1'b1};
   localparam lock_action_type ACT_HLUP         = '{1'b0, 1'b0, 1'b1, EV_HLUP, 1'b1};

   // Lock decode, indexed by {hold_seen, hold passed, jitter passed, keys differ}
   localparam lock_action_type LOCK_TABLE [0:15] = '{
      ACT_REFRESH,      ACT_NONE,         ACT_REFRESH,      ACT_UP,
      ACT_HOLD,         ACT_HOLD_REFRESH, ACT_HOLD_REFRESH, ACT_HLUP,
      ACT_REFRESH,      ACT_HOLD_REFRESH, ACT_REFRESH,      ACT_HLUP,
      ACT_REFRESH,      ACT_NONE,         ACT_REFRESH,      ACT_HLUP
   };

endpackage

[hw/rtl/tbed_if.sv]
// Channel interfaces: poll input, event output and register writes

interface tbed_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [1:0]  pressed;

   modport source (output valid, output now_ms, output pressed, input ready);
   modport sink   (input valid, input now_ms, input pressed, output ready);
endinterface

interface tbed_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [1:0] event_keys;

   modport source (output valid, output event_kind, output event_keys, input ready);
   modport sink   (input valid, input event_kind, input event_keys, output ready);
endinterface

interface tbed_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/tbed_core.sv]
// Phase machine and lock decode of the event detector, one poll per step
module tbed_core #(
   parameter int KEY_COUNT = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [31:0]         now_ms,
   input  logic [1:0]          pressed,
   input  tbed_pkg::cfg_type   cfg,
   output tbed_pkg::event_type event_o
);
   import tbed_pkg::*;

   localparam int KW = (KEY_COUNT > PORT_KEYS_W) ? KEY_COUNT : PORT_KEYS_W;

   phase_type              phase_ff, phase_in;
   logic [KEY_COUNT-1:0]   gathered_ff, gathered_in;
   logic [KEY_COUNT-1:0]   locked_ff, locked_in;
   logic                   hold_seen_ff, hold_seen_in;
   logic [STAMP_W-1:0]     start_ff, start_in;
   logic [STAMP_W-1:0]     jitter_ff, jitter_in;

   logic [KW-1:0]          pressed_wide;
   logic [KW-1:0]          locked_wide;
   logic [KEY_COUNT-1:0]   keys;
   logic [KEY_COUNT-1:0]   gathered_merged;
   logic [STAMP_W-1:0]     d_start;
   logic [STAMP_W-1:0]     d_jitter;
   logic                   poll_passed;
   logic                   hold_passed;
   logic                   jitter_passed;
   logic                   inactive_passed;
   logic                   keys_differ;
   logic [3:0]             lock_code;
   lock_action_type        act;
   logic                   ev_valid;
   event_kind_type         ev_kind;

   // Key bits beyond the port width read as zero; extra port bits are dropped
   assign pressed_wide    = KW'(pressed);
   assign keys            = pressed_wide[KEY_COUNT-1:0];
   assign gathered_merged = gathered_ff | keys;

   // Elapsed times wrap modulo 2^32
   assign d_start  = now_ms - start_ff;
   assign d_jitter = now_ms - jitter_ff;

   assign poll_passed     = d_start  > STAMP_W'(cfg.poll_window_ms);
   assign hold_passed     = d_start  > STAMP_W'(cfg.hold_time_ms);
   assign jitter_passed   = d_jitter > STAMP_W'(cfg.jitter_window_ms);
   assign inactive_passed = d_start  > STAMP_W'(cfg.inactive_time_ms);
   assign keys_differ     = locked_ff != gathered_merged;

   assign lock_code = {hold_seen_ff, hold_passed, jitter_passed, keys_differ};
   assign act       = LOCK_TABLE[lock_code];

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_WAIT: if (|gathered_merged) phase_in = PH_POLL;
         PH_POLL: if (poll_passed) phase_in = PH_LOCK;
         PH_LOCK: if (act.release_keys) phase_in = PH_IACT;
         PH_IACT: if (inactive_passed) phase_in = PH_WAIT;
         default: phase_in = PH_WAIT;
      endcase
   end

   // Keys, stamps and event per phase
   always_comb begin
      gathered_in  = gathered_merged;
      locked_in    = locked_ff;
      hold_seen_in = hold_seen_ff;
      start_in     = start_ff;
      jitter_in    = jitter_ff;
      ev_valid     = 1'b0;
      ev_kind      = EV_DOWN;
      case (phase_ff)
         PH_WAIT: begin
            if (|gathered_merged) start_in = now_ms;
         end
         PH_POLL: begin
            if (poll_passed) begin
               locked_in   = locked_ff | gathered_merged;
               gathered_in = '0;
               start_in    = now_ms;
               jitter_in   = now_ms;
               ev_valid    = 1'b1;
               ev_kind     = EV_DOWN;
            end
         end
         PH_LOCK: begin
            gathered_in = '0;
            if (act.refresh_jitter) jitter_in = now_ms;
            if (act.set_hold) hold_seen_in = 1'b1;
            if (act.release_keys) start_in = now_ms;
            ev_valid = act.emit;
            ev_kind  = act.kind;
         end
         default: begin
            gathered_in  = '0;
            locked_in    = '0;
            hold_seen_in = 1'b0;
         end
      endcase
   end

   // Event carries the locked set after this step
   assign locked_wide = KW'(locked_in);
   assign event_o     = '{valid: ev_valid & step_en, kind: ev_kind,
                          keys: locked_wide[PORT_KEYS_W-1:0]};

   // State registers advance once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         gathered_ff  <= '0;
         locked_ff    <= '0;
         hold_seen_ff <= 1'b0;
         start_ff     <= '0;
         jitter_ff    <= '0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         gathered_ff  <= gathered_in;
         locked_ff    <= locked_in;
         hold_seen_ff <= hold_seen_in;
         start_ff     <= start_in;
         jitter_ff    <= jitter_in;
      end
   end

endmodule

[hw/rtl/two_button_event_detector_top.sv]
// Two-button event detector: poll channel in, press/hold/release events out
//
// Each poll item (now_ms, pressed) is taken into an input register, run
// through the phase machine once the result register has room, and its
// event, if it has one, lands in the result register; one item per cycle is
// sustained while the result channel does not stall. The input register frees
// up whenever the result register is empty or being taken, so req_chan.ready
// drops only while a result waits and another item sits in the input register.
// Register writes are taken at once (csr_chan.ready is always high); indexes
// past the last register are ignored. Configure only while no item is in flight.
module two_button_event_detector_top #(
   parameter int KEY_COUNT = 2
) (
   input logic      clock,
   input logic      reset,
   tbed_req_if.sink   req_chan,
   tbed_rsp_if.source rsp_chan,
   tbed_csr_if.sink   csr_chan
);
   import tbed_pkg::*;

   cfg_type             cfg_ff;
   logic                s1_valid_ff;
   logic [STAMP_W-1:0]  s1_now_ff;
   logic [1:0]          s1_pressed_ff;
   logic                rsp_valid_ff;
   event_kind_type      rsp_kind_ff;
   logic [1:0]          rsp_keys_ff;
   logic                advance;
   logic                req_take;
   event_type           event_w;

   // Register write port
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{poll_window_ms:   POLL_WINDOW_RESET,
                     jitter_window_ms: JITTER_WINDOW_RESET,
                     hold_time_ms:     HOLD_TIME_RESET,
                     inactive_time_ms: INACTIVE_TIME_RESET};
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_POLL_WINDOW:   cfg_ff.poll_window_ms   <= csr_chan.data;
            CSR_JITTER_WINDOW: cfg_ff.jitter_window_ms <= csr_chan.data;
            CSR_HOLD_TIME:     cfg_ff.hold_time_ms     <= csr_chan.data;
            CSR_INACTIVE_TIME: cfg_ff.inactive_time_ms <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Input stage moves on when the result register has room
   assign advance        = s1_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~s1_valid_ff | advance;
   assign req_take       = req_chan.valid & req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_now_ff     <= req_chan.now_ms;
         s1_pressed_ff <= req_chan.pressed;
      end
   end

   tbed_core #(
      .KEY_COUNT (KEY_COUNT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .now_ms  (s1_now_ff),
      .pressed (s1_pressed_ff),
      .cfg     (cfg_ff),
      .event_o (event_w)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= event_w.valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && event_w.valid) begin
         rsp_kind_ff <= event_w.kind;
         rsp_keys_ff <= event_w.keys;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.event_kind = rsp_kind_ff;
   assign rsp_chan.event_keys = rsp_keys_ff;

endmodule

[hw/rtl/tbed_checker.sv]
// Port-level checks of the event detector and their bind to the top level
`include "two_button_event_detector_top_assert.svh"

module tbed_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event_kind,
   input logic [1:0] rsp_event_keys
);

   // Reset empties the result register
   `TBED_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result holds its item
   `TBED_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) && $stable(rsp_event_keys), "stalled result changed")

   // Input is never blocked while the output side has room
   `TBED_ASSERT(a_req_ready_free, clock, reset, (!rsp_valid || rsp_ready) |-> req_ready, "input stalled with free output")

   // Input only stalls behind a waiting result
   `TBED_ASSERT(a_req_stall_cause, clock, reset, (req_valid && !req_ready) |-> (rsp_valid && !rsp_ready), "input stalled without cause")

endmodule

bind two_button_event_detector_top tbed_checker u_tbed_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_event_kind (rsp_chan.event_kind),
   .rsp_event_keys (rsp_chan.event_keys)
);
